// File: design/rsde_pkg.sv
// ----------------------------------------------------------------------------
// rsde_pkg
// Shared types, register map and a helper function for the reference-series
// delta encoder.
// ----------------------------------------------------------------------------
package rsde_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_FIRST    = 2'd0,
        KIND_TEMPORAL = 2'd1,
        KIND_REF      = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_REF_INTERVAL  = 2'd0,
        REG_SERIES_LENGTH = 2'd1,
        REG_FLOOR_VALUE   = 2'd2,
        REG_REF_MODE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]        ref_interval;
        logic [10:0]       series_length;
        logic [DATA_W-1:0] floor_value;
        logic              ref_mode;
    } cfg_t;

    // one sample after sequencing, waiting for its reference read
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic [DATA_W-1:0] other;
        kind_t             kind;
        logic              series_end;
    } stage_t;

    function automatic logic [DATA_W-1:0] zigzag(input logic [DATA_W-1:0] d);
        return {d[DATA_W-2:0], 1'b0} ^ {DATA_W{d[DATA_W-1]}};
    endfunction

endpackage

// File: design/rsde_cfg_regs.sv
// ----------------------------------------------------------------------------
// rsde_cfg_regs
// APB register file holding the encoder configuration.
// ----------------------------------------------------------------------------
module rsde_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rsde_pkg::cfg_t      cfg
);

    rsde_pkg::cfg_t     cfg_reg;
    rsde_pkg::cfg_t     cfg_next;
    rsde_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = rsde_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                rsde_pkg::REG_REF_INTERVAL:  cfg_next.ref_interval  = pwdata[7:0];
                rsde_pkg::REG_SERIES_LENGTH: cfg_next.series_length = pwdata[10:0];
                rsde_pkg::REG_FLOOR_VALUE:   cfg_next.floor_value   = pwdata;
                rsde_pkg::REG_REF_MODE:      cfg_next.ref_mode      = pwdata[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            rsde_pkg::REG_REF_INTERVAL:  prdata = {24'd0, cfg_reg.ref_interval};
            rsde_pkg::REG_SERIES_LENGTH: prdata = {21'd0, cfg_reg.series_length};
            rsde_pkg::REG_FLOOR_VALUE:   prdata = cfg_reg.floor_value;
            rsde_pkg::REG_REF_MODE:      prdata = {31'd0, cfg_reg.ref_mode};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_interval  <= 8'd1;
            cfg_reg.series_length <= 11'd1024;
            cfg_reg.floor_value   <= 32'd0;
            cfg_reg.ref_mode      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/rsde_ref_mem.sv
// ----------------------------------------------------------------------------
// rsde_ref_mem
// Reference series store: one write port, one registered read port.
// A read and write to the same entry in one cycle returns the old data.
// ----------------------------------------------------------------------------
module rsde_ref_mem
#(
    parameter int DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [rsde_pkg::DATA_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [rsde_pkg::DATA_W-1:0]    rd_data
);

    logic [rsde_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rsde_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/rsde_seq.sv
// ----------------------------------------------------------------------------
// rsde_seq
// Series sequencer: tracks sample index, group position and coding choice,
// issues the reference store access and builds the stage-one record.
// ----------------------------------------------------------------------------
module rsde_seq
#(
    parameter int MAX_SAMPLES = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rsde_pkg::cfg_t                   cfg,
    input  logic                             accept,
    input  logic [rsde_pkg::DATA_W-1:0]      sample,
    input  logic                             gstart,
    input  logic                             lgroup,
    output logic                             mem_we,
    output logic [$clog2(MAX_SAMPLES)-1:0]   mem_addr,
    output rsde_pkg::stage_t                 info
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = (IW + 1 > 11) ? IW + 1 : 11;
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_SAMPLES);

    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               idx_next;
    logic [7:0]                  sig_reg;
    logic [7:0]                  sig_next;
    logic                        temporal_reg;
    logic                        temporal_next;
    logic [rsde_pkg::DATA_W-1:0] prev_reg;

    logic [CW-1:0] len_raw;
    logic [CW-1:0] len;
    logic [IW-1:0] idx_eff;
    logic [7:0]    sig_eff;
    logic          first;
    logic          temporal;
    logic          last_smp;
    logic [8:0]    sig_inc;

    always_comb
    begin
        len_raw = CW'(cfg.series_length);
        priority if (len_raw == '0)
            len = CW'(1);
        else if (len_raw > LEN_MAX)
            len = LEN_MAX;
        else
            len = len_raw;

        idx_eff = (gstart || CW'(idx_reg) >= len) ? '0 : idx_reg;
        sig_eff = gstart ? 8'd0 : sig_reg;
        first   = (idx_eff == '0);

        priority if (!first)
            temporal = temporal_reg;
        else if (lgroup)
            temporal = 1'b1;
        else if (cfg.ref_mode)
            temporal = gstart;
        else
            temporal = (sig_eff == 8'd0);

        last_smp = (CW'(idx_eff) + CW'(1) >= len);
        sig_inc  = {1'b0, sig_eff} + 9'd1;

        idx_next      = last_smp ? '0 : idx_eff + IW'(1);
        sig_next      = last_smp ? ((sig_inc >= {1'b0, cfg.ref_interval}) ? 8'd0
                                                                       : sig_inc[7:0])
                                 : sig_eff;
        temporal_next = temporal;
    end

    assign mem_addr = idx_eff;
    assign mem_we   = accept && (cfg.ref_mode || temporal);

    always_comb
    begin
        info.sample     = sample;
        info.other      = first ? cfg.floor_value : prev_reg;
        info.series_end = last_smp;
        priority if (!temporal)
            info.kind = rsde_pkg::KIND_REF;
        else if (first)
            info.kind = rsde_pkg::KIND_FIRST;
        else
            info.kind = rsde_pkg::KIND_TEMPORAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            sig_reg      <= 8'd0;
            temporal_reg <= 1'b0;
            prev_reg     <= '0;
        end
        else if (accept)
        begin
            idx_reg      <= idx_next;
            sig_reg      <= sig_next;
            temporal_reg <= temporal_next;
            prev_reg     <= sample;
        end
    end

    a_end_wraps_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_smp) |=> (idx_reg == '0))
        else $error("index not cleared after series end");

    a_ref_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg.ref_mode && info.kind == rsde_pkg::KIND_REF) |-> !mem_we)
        else $error("reference-coded series written in mode 0");

endmodule

// File: design/reference_series_delta_encoder.sv
// ----------------------------------------------------------------------------
// reference_series_delta_encoder
// Delta / zigzag encoder of sensor series against a stored reference series.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one sample per transfer, tdata = sample_value,
//   tuser = {last_group, group_start}. Output stream (m_axis_*): one code per
//   input transfer, tdata = code, tuser = kind, tlast = series_end.
//   Configure over the APB port only while the stream is idle (not enforced).
//   A transfer is registered in stage one together with its reference store
//   read, then the subtract / zigzag result goes into the output register.
//   Throughput: one sample per cycle; each sample costs one read and at most
//   one write of the reference store, both issued in the transfer cycle.
//   When the receiver stalls, the output register holds its code, the next
//   sample waits in stage one, and s_axis_tready drops once both are full.
//   Reset clears the sequencer and the configuration to its defaults; the
//   reference store is not cleared and is valid once a reference series
//   has been written.
// ----------------------------------------------------------------------------
module reference_series_delta_encoder
#(
    parameter int MAX_SAMPLES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
    input  logic [1:0]  s_axis_tuser,   // [0] group_start, [1] last_group
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_SAMPLES);

    rsde_pkg::cfg_t              cfg;
    rsde_pkg::stage_t            info;
    rsde_pkg::stage_t            s1_reg;
    logic                        s1_valid_reg;
    logic                        accept;
    logic                        s1_adv;
    logic                        mem_we;
    logic [IW-1:0]               mem_addr;
    logic [rsde_pkg::DATA_W-1:0] ref_data;
    logic [rsde_pkg::DATA_W-1:0] operand;
    logic [rsde_pkg::DATA_W-1:0] diff;
    logic [rsde_pkg::DATA_W-1:0] code_next;
    logic [rsde_pkg::DATA_W-1:0] code_reg;
    rsde_pkg::kind_t             kind_reg;
    logic                        end_reg;
    logic                        out_valid_reg;

    rsde_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsde_seq #(.MAX_SAMPLES(MAX_SAMPLES)) u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .sample   (s_axis_tdata),
        .gstart   (s_axis_tuser[0]),
        .lgroup   (s_axis_tuser[1]),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .info     (info)
    );

    rsde_ref_mem #(.DEPTH(MAX_SAMPLES)) u_mem
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (accept),
        .rd_addr (mem_addr),
        .rd_data (ref_data)
    );

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        operand   = (s1_reg.kind == rsde_pkg::KIND_REF) ? ref_data : s1_reg.other;
        diff      = s1_reg.sample - operand;
        code_next = (s1_reg.kind == rsde_pkg::KIND_FIRST) ? diff : rsde_pkg::zigzag(diff);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= info;
        end
        if (s1_adv)
        begin
            code_reg <= code_next;
            kind_reg <= s1_reg.kind;
            end_reg  <= s1_reg.series_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = code_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = end_reg;

    a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_axis_tvalid)
        else $error("stage one advanced without loading output");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!s1_valid_reg || s1_adv))
        else $error("stage one overwritten before it advanced");

endmodule

// File: verif/reference_series_delta_encoder_tb.sv
// ----------------------------------------------------------------------------
// reference_series_delta_encoder_tb
// Self-checking bench for the reference-series delta encoder. A behavioral
// encoder model tracks sequencing, reference store and configuration, and
// predicts code, kind and series end for every accepted sample. Directed
// sequences cover wrap-around, late flags, group starts mid-series, length
// and interval corner values and both reference modes. Random phases then
// stream well-formed series with noise under varying stream back-pressure.
// ----------------------------------------------------------------------------
module reference_series_delta_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES = 1024;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        logic [31:0]     code;
        rsde_pkg::kind_t kind;
        logic            last;
    } code_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // encoder model: configuration
    logic [7:0]  cfg_interval = 8'd1;
    logic [10:0] cfg_length   = 11'd1024;
    logic [31:0] cfg_min      = '0;
    logic        cfg_mode     = 1'b0;

    // encoder model: sequencing and reference store
    logic [31:0] enc_ref [MAX_SAMPLES];
    bit          enc_written [MAX_SAMPLES];
    logic [31:0] enc_prev      = '0;
    logic [9:0]  enc_index     = '0;
    logic [7:0]  enc_group_pos = '0;
    logic        enc_temporal  = 1'b0;

    code_word_t  pending_codes[$];

    int error_count      = 0;
    int samples_sent     = 0;
    int codes_checked    = 0;
    int settings_applied = 0;
    int sender_idle_pct  = 0;
    int sink_stall_pct   = 0;

    reference_series_delta_encoder #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [31:0] fold_sign(input logic [31:0] d);
        return (d << 1) ^ (d[31] ? 32'hFFFF_FFFF : 32'h0);
    endfunction

    function automatic int eff_length();
        int len;
        len = int'(cfg_length);
        if (len < 1)
            len = 1;
        if (len > MAX_SAMPLES)
            len = MAX_SAMPLES;
        return len;
    endfunction

    // true if this sample would be coded against a never-written store entry
    function automatic bit reads_unwritten(input logic gs, input logic lg);
        int   idx;
        logic gpos_zero;
        logic temporal;
        idx       = gs ? 0 : int'(enc_index);
        gpos_zero = gs ? 1'b1 : (enc_group_pos == 8'd0);
        if (idx >= eff_length())
            idx = 0;
        if (idx == 0)
            temporal = lg || (cfg_mode ? gs : gpos_zero);
        else
            temporal = enc_temporal;
        return !temporal && !enc_written[idx];
    endfunction

    task automatic encode_sample(input logic [31:0] sample, input logic gs,
                                 input logic lg, output code_word_t res);
        int         len;
        logic [8:0] next_pos;
        len = eff_length();
        if (gs)
        begin
            enc_index     = '0;
            enc_group_pos = '0;
        end
        if (int'(enc_index) >= len)
            enc_index = '0;
        if (enc_index == 0)
            enc_temporal = lg ? 1'b1 : (cfg_mode ? gs : (enc_group_pos == 8'd0));
        if (!enc_temporal)
        begin
            res.code = fold_sign(sample - enc_ref[enc_index]);
            res.kind = rsde_pkg::KIND_REF;
        end
        else if (enc_index == 0)
        begin
            res.code = sample - cfg_min;
            res.kind = rsde_pkg::KIND_FIRST;
        end
        else
        begin
            res.code = fold_sign(sample - enc_prev);
            res.kind = rsde_pkg::KIND_TEMPORAL;
        end
        if (cfg_mode || enc_temporal)
        begin
            enc_ref[enc_index]     = sample;
            enc_written[enc_index] = 1'b1;
        end
        enc_prev = sample;
        res.last = (int'(enc_index) + 1 >= len);
        if (res.last)
        begin
            next_pos      = {1'b0, enc_group_pos} + 9'd1;
            enc_index     = '0;
            enc_group_pos = (next_pos >= {1'b0, cfg_interval}) ? 8'd0 : next_pos[7:0];
        end
        else
        begin
            enc_index = enc_index + 10'd1;
        end
    endtask

    task automatic push_sample(input logic [31:0] sample, input logic gs, input logic lg);
        int         gap;
        code_word_t res;
        gap = 0;
        if (reads_unwritten(gs, lg))
            gs = 1'b1;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= {lg, gs};
        do
            @(posedge clk);
        while (!s_axis_tready);
        encode_sample(sample, gs, lg, res);
        pending_codes = {pending_codes, res};
        samples_sent++;
    endtask

    task automatic drain_codes();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_codes.size() != 0)
        begin
            $display("%0t ERROR: %0d expected codes never arrived", $realtime,
                     pending_codes.size());
            error_count++;
            pending_codes.delete();
        end
    endtask

    task automatic apb_write(input rsde_pkg::reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rsde_pkg::REG_REF_INTERVAL:  cfg_interval = value[7:0];
            rsde_pkg::REG_SERIES_LENGTH: cfg_length   = value[10:0];
            rsde_pkg::REG_FLOOR_VALUE:   cfg_min      = value;
            rsde_pkg::REG_REF_MODE:      cfg_mode     = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] k, input logic [10:0] len,
                             input logic [31:0] min_val, input logic mode);
        drain_codes();
        apb_write(rsde_pkg::REG_REF_INTERVAL, {24'h0, k});
        apb_write(rsde_pkg::REG_SERIES_LENGTH, {21'h0, len});
        apb_write(rsde_pkg::REG_FLOOR_VALUE, min_val);
        apb_write(rsde_pkg::REG_REF_MODE, {31'h0, mode});
        settings_applied++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t ERROR: unexpected code %h kind %0d last %b", $realtime,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                code_word_t exp_word;
                exp_word = pending_codes.pop_front();
                codes_checked++;
                if (m_axis_tdata !== exp_word.code)
                begin
                    $display("%0t ERROR: code expected %h actual %h", $realtime,
                             exp_word.code, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== exp_word.kind)
                begin
                    $display("%0t ERROR: kind expected %0d actual %0d", $realtime,
                             exp_word.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== exp_word.last)
                begin
                    $display("%0t ERROR: series end expected %b actual %b", $realtime,
                             exp_word.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // wrap-around deltas, late flags, group start mid-series, last group
    task automatic test_reference_series();
        configure(8'd2, 11'd3, 32'hFFFF_FFFB, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        push_sample(32'h8000_0000, 1'b0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_sample(32'h0000_0000, 1'b0, 1'b0);
        push_sample(32'h0000_0001, 1'b0, 1'b1);
        push_sample(32'h8000_0000, 1'b0, 1'b0);
        push_sample(32'h0000_0005, 1'b0, 1'b0);
        push_sample(32'h0000_0009, 1'b1, 1'b0);
        push_sample(32'h0000_0000, 1'b0, 1'b0);
        push_sample(32'h0000_0003, 1'b0, 1'b0);
        push_sample(32'h0000_0064, 1'b0, 1'b1);
        push_sample(32'hFFFF_FF9C, 1'b0, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    endtask

    // length one, zero, above the store size, and shortened mid-series
    task automatic test_length_limits();
        configure(8'd2, 11'd1, 32'h0, 1'b0);
        push_sample(32'h1234_5678, 1'b0, 1'b0);
        push_sample(32'h8000_0000, 1'b0, 1'b0);
        configure(8'd2, 11'd0, 32'h7FFF_FFFF, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_sample(32'h0000_0000, 1'b0, 1'b0);
        configure(8'd1, 11'd2047, 32'h0, 1'b0);
        push_sample(32'h0000_0010, 1'b1, 1'b0);
        push_sample(32'h0000_0020, 1'b0, 1'b0);
        push_sample(32'h0000_0008, 1'b0, 1'b0);
        configure(8'd1, 11'd2, 32'h0, 1'b0);
        push_sample(32'h0000_0011, 1'b0, 1'b0);
        push_sample(32'h0000_0012, 1'b0, 1'b0);
    endtask

    task automatic test_interval_zero();
        configure(8'd0, 11'd2, 32'h8000_0000, 1'b0);
        push_sample(32'h0000_0001, 1'b0, 1'b0);
        push_sample(32'h0000_0002, 1'b0, 1'b0);
        push_sample(32'hFFFF_FFFE, 1'b0, 1'b0);
        push_sample(32'h0000_0004, 1'b0, 1'b0);
    endtask

    task automatic test_previous_series_mode();
        configure(8'd3, 11'd2, 32'h0, 1'b1);
        push_sample(32'h0000_0100, 1'b1, 1'b0);
        push_sample(32'h0000_0101, 1'b0, 1'b0);
        push_sample(32'h0000_00FF, 1'b0, 1'b0);
        push_sample(32'h8000_0101, 1'b0, 1'b0);
        push_sample(32'h0000_0100, 1'b0, 1'b0);
    endtask

    task automatic run_random_phase(input int items, input int s_idle, input int r_stall,
                                    input logic [7:0] k, input logic [10:0] len,
                                    input logic [31:0] min_val, input logic mode);
        logic [31:0] sample;
        logic        gs;
        logic        lg;
        int          sel;
        int          idx;
        configure(k, len, min_val, mode);
        sender_idle_pct = s_idle;
        sink_stall_pct  = r_stall;
        for (int n = 0; n < items; n++)
        begin
            idx = int'(enc_index);
            if (idx >= eff_length())
                idx = 0;
            if (idx == 0)
            begin
                gs = ($urandom_range(9) == 0);
                lg = ($urandom_range(4) == 0);
            end
            else
            begin
                gs = ($urandom_range(49) == 0);
                lg = ($urandom_range(9) == 0);
            end
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                case ($urandom_range(3))
                    0: sample = 32'h8000_0000;
                    1: sample = 32'h7FFF_FFFF;
                    2: sample = 32'h0000_0000;
                    default: sample = 32'hFFFF_FFFF;
                endcase
            end
            else if (sel < 30)
                sample = $urandom;
            else if (sel < 65 || !enc_written[idx])
                sample = enc_prev + 32'($urandom_range(64)) - 32'd32;
            else
                sample = enc_ref[idx] + 32'($urandom_range(64)) - 32'd32;
            push_sample(sample, gs, lg);
        end
    endtask

    task automatic test_random_streams();
        run_random_phase(80, 0, 0, 8'd1, 11'd2, 32'h8000_0000, 1'b0);
        run_random_phase(80, 85, 0, 8'd3, 11'd5, $urandom, 1'b0);
        run_random_phase(80, 0, 85, 8'd255, 11'd7, 32'h7FFF_FFFF, 1'b1);
        run_random_phase(80, 24, 24, 8'($urandom_range(6, 2)),
                         11'($urandom_range(16, 2)), $urandom, 1'b1);
        run_random_phase(500, 0, 0, 8'd2, 11'd1024, 32'h0, 1'b0);
        run_random_phase(80, 85, 0, 8'($urandom_range(4, 1)),
                         11'($urandom_range(12, 2)), $urandom, 1'b0);
        run_random_phase(80, 0, 85, 8'd4, 11'd3, $urandom, 1'b1);
        run_random_phase(80, 24, 24, 8'd255, 11'd16, $urandom, 1'b0);
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reference_series();
        test_length_limits();
        test_interval_zero();
        test_previous_series_mode();
        test_random_streams();
        drain_codes();
        repeat (10) @(posedge clk);
        $display("Encoded %0d samples, %0d codes checked, %0d register settings applied",
                 samples_sent, codes_checked, settings_applied);
        $display("Both reference modes, lengths 0 to 2047, intervals 0 to 255, four idle profiles");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/rsde_pkg.sv
design/rsde_cfg_regs.sv
design/rsde_ref_mem.sv
design/rsde_seq.sv
design/reference_series_delta_encoder.sv
verif/reference_series_delta_encoder_tb.sv
